@@ rtl/core/fsa_pkg.sv @@
package fsa_pkg;

    // Request and response codes.
    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_EMPTY        = 3'd1,
        STATUS_NOT_IN_POOL  = 3'd2,
        STATUS_MISALIGNED   = 3'd3,
        STATUS_ALREADY_FREE = 3'd4
    } status_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_ELEMENT_BYTES = 1'b0,
        CFG_POOL_BASE     = 1'b1
    } cfg_index_t;

    localparam int EB_W            = 11;
    localparam int CFG_W           = 32;
    localparam logic [EB_W-1:0] EB_RESET = 11'd16;

    typedef struct packed {
        command_t    command;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] slot_address;
        logic [7:0]  free_count;
        logic [7:0]  used_count;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_WB,
        ST_CHECK,
        ST_DIV,
        ST_WALK,
        ST_LINK,
        ST_SPLICE,
        ST_RESP
    } state_t;

endpackage

@@ rtl/core/fixed_slot_allocator.sv @@
// Sequence: an allocate passes through ALLOC_RD, ALLOC_WB and RESP before its item is
// registered; a free passes through CHECK, the one-step-per-cycle divider, a walk over at
// most free-count list entries paced by the link read port, LINK and, if needed, SPLICE.
// Throughput: one item at a time; the next item is accepted once the result is registered.
// Reset: asynchronous, active low; afterwards a clearing pass over every slot rebuilds the
// descending free list in the link memory, and no item is accepted until it completes.
module fixed_slot_allocator #(
    parameter int SLOTS = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  fsa_pkg::req_t             in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output fsa_pkg::rsp_t             out_data,
    input  logic                      cfg_we,
    input  fsa_pkg::cfg_index_t       cfg_index,
    input  logic [fsa_pkg::CFG_W-1:0] cfg_data
);
    import fsa_pkg::*;

    // Slot index, count, pool extent, divider remainder and divider step widths.
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int EXT_W  = EB_W + CNT_W;
    localparam int REM_W  = EB_W + IDX_W;
    localparam int STEP_W = $clog2(IDX_W);

    // The free list links live in a single-port-write, single-port-read memory. Each entry
    // holds the index of the next lower free slot; the end of the list is given by the
    // free count, not by a marker.
    logic [IDX_W-1:0] link_mem [SLOTS];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [IDX_W-1:0] rd_q;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [EB_W-1:0]  eb_reg, eb_next;
    logic [31:0]      base_reg, base_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic             out_valid_reg, out_valid_next;

    // Per-item working registers; these carry payload and need no reset.
    logic [31:0]       offset_reg, offset_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  prev_reg, prev_next;
    logic              have_prev_reg, have_prev_next;
    logic              from_mem_reg, from_mem_next;
    logic [CNT_W-1:0]  walk_reg, walk_next;
    status_t           st_reg, st_next;
    logic [31:0]       addr_reg, addr_next;
    rsp_t              out_data_reg, out_data_next;

    // Datapath helpers.
    logic [EXT_W-1:0]  extent;
    logic [REM_W-1:0]  prod;
    logic [REM_W-1:0]  dsh;
    logic [REM_W-1:0]  rem_sub;
    logic [IDX_W-1:0]  quo;
    logic [IDX_W-1:0]  cur;
    logic              walk_on;
    logic [CNT_W+7:0]  free_ext;
    logic [CNT_W+7:0]  used_ext;
    logic              in_accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Extent of the pool in bytes; a zero element size gives a pool with no extent, so
    // every free lands in the not-in-pool case and the divider is never started.
    assign extent = EXT_W'(eb_reg) * EXT_W'(SLOTS);

    // Byte offset of the slot at the head of the list, for an allocate.
    assign prod = REM_W'(eb_reg) * REM_W'(head_reg);

    // The walk compares against the register copy on its first step and against the
    // freshly read link afterwards.
    assign cur     = from_mem_reg ? rd_q : cur_reg;
    assign walk_on = (walk_reg != '0) && (idx_reg < cur);

    assign free_ext = {8'b0, free_reg};
    assign used_ext = {8'b0, used_reg};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        eb_next        = eb_reg;
        base_next      = base_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg;
        offset_next    = offset_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        from_mem_next  = from_mem_reg;
        walk_next      = walk_reg;
        st_next        = st_reg;
        addr_next      = addr_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        dsh            = REM_W'(eb_reg) << step_reg;
        rem_sub        = rem_reg;
        quo            = idx_reg;

        // Configuration writes are taken in any state.
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ELEMENT_BYTES: eb_next   = cfg_data[EB_W-1:0];
                CFG_POOL_BASE:     base_next = cfg_data[31:0];
                default:           ;
            endcase
        end

        // The output register empties when its item is taken.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Rebuild the reset list: slot i links to slot i-1, slot 0 to itself.
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg == '0) ? '0 : clr_reg - IDX_W'(1);
                if (clr_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    addr_next = '0;
                    if (in_data.command == CMD_FREE)
                    begin
                        offset_next = in_data.address - base_reg;
                        state_next  = ST_CHECK;
                    end
                    else if (free_reg == '0)
                    begin
                        st_next    = STATUS_EMPTY;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_ALLOC_RD;
                    end
                end
            end

            ST_ALLOC_RD:
            begin
                // Fetch the head's link while the slot address is formed.
                mem_re     = 1'b1;
                mem_raddr  = head_reg;
                addr_next  = base_reg + 32'(prod);
                state_next = ST_ALLOC_WB;
            end

            ST_ALLOC_WB:
            begin
                head_next  = rd_q;
                free_next  = free_reg - CNT_W'(1);
                used_next  = used_reg + CNT_W'(1);
                st_next    = STATUS_OK;
                state_next = ST_RESP;
            end

            ST_CHECK:
            begin
                if (32'(extent) <= offset_reg)
                begin
                    st_next    = STATUS_NOT_IN_POOL;
                    state_next = ST_RESP;
                end
                else
                begin
                    // The offset is below the extent, so it fits the remainder register
                    // and the quotient fits a slot index.
                    rem_next   = offset_reg[REM_W-1:0];
                    idx_next   = '0;
                    step_next  = STEP_W'(IDX_W - 1);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // Restoring division, one quotient bit per cycle, most significant first.
                if (rem_reg >= dsh)
                begin
                    rem_sub        = rem_reg - dsh;
                    quo[step_reg]  = 1'b1;
                end
                rem_next = rem_sub;
                idx_next = quo;
                if (step_reg == '0)
                begin
                    if (rem_sub != '0)
                    begin
                        st_next    = STATUS_MISALIGNED;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        cur_next       = head_reg;
                        walk_next      = free_reg;
                        from_mem_next  = 1'b0;
                        have_prev_next = 1'b0;
                        state_next     = ST_WALK;
                    end
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end

            ST_WALK:
            begin
                if (walk_on)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = cur;
                    prev_next      = cur;
                    have_prev_next = 1'b1;
                    walk_next      = walk_reg - CNT_W'(1);
                    from_mem_next  = 1'b1;
                end
                else
                begin
                    cur_next      = cur;
                    from_mem_next = 1'b0;
                    if ((walk_reg != '0) && (idx_reg == cur))
                    begin
                        st_next    = STATUS_ALREADY_FREE;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_LINK;
                    end
                end
            end

            ST_LINK:
            begin
                // The freed slot points at the first lower free slot, if any.
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = (walk_reg != '0) ? cur_reg : '0;
                if (have_prev_reg)
                begin
                    state_next = ST_SPLICE;
                end
                else
                begin
                    head_next  = idx_reg;
                    free_next  = free_reg + CNT_W'(1);
                    used_next  = (used_reg != '0) ? used_reg - CNT_W'(1) : used_reg;
                    st_next    = STATUS_OK;
                    state_next = ST_RESP;
                end
            end

            ST_SPLICE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = prev_reg;
                mem_wdata  = idx_reg;
                free_next  = free_reg + CNT_W'(1);
                used_next  = (used_reg != '0) ? used_reg - CNT_W'(1) : used_reg;
                st_next    = STATUS_OK;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = st_reg;
                    out_data_next.slot_address = addr_reg;
                    out_data_next.free_count   = free_ext[7:0];
                    out_data_next.used_count   = used_ext[7:0];
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            eb_reg        <= EB_RESET;
            base_reg      <= '0;
            head_reg      <= IDX_W'(SLOTS - 1);
            free_reg      <= CNT_W'(SLOTS);
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            eb_reg        <= eb_next;
            base_reg      <= base_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg    <= offset_next;
        idx_reg       <= idx_next;
        rem_reg       <= rem_next;
        step_reg      <= step_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        from_mem_reg  <= from_mem_next;
        walk_reg      <= walk_next;
        st_reg        <= st_next;
        addr_reg      <= addr_next;
        out_data_reg  <= out_data_next;
    end

    // Link memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q <= link_mem[mem_raddr];
        end
    end

    // Every slot is either on the free list or allocated.
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W + 1)'(free_reg) + (CNT_W + 1)'(used_reg)) == (CNT_W + 1)'(SLOTS))
        else $error("free and used counts do not add up to the pool size");

    // A walk never has more entries left than the list holds.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (walk_reg <= free_reg))
        else $error("list walk ran past the free count");

    // A pool-empty answer goes out only with an empty free list.
    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && st_reg == STATUS_EMPTY) |-> (free_reg == '0))
        else $error("pool empty reported with free slots left");

endmodule
